@@ sv/uves_pkg.sv @@
// Shared types, constants and fixed-point helpers for the unit vector to
// Euler angle sampler. No dependencies.
package uves_pkg;

    // Work angles are Q30 radians in a wide signed word
    localparam int ANG_W           = 35;
    localparam int WORK_FRAC       = 30;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_SHIFT       = WORK_FRAC - ANGLE_FRAC_BITS;
    localparam int UNIT_Q14        = 16384;

    // pi is four times the first arctangent entry
    localparam logic signed [ANG_W-1:0] PI_WORK      = 35'sd3373259428;
    localparam logic signed [ANG_W-1:0] QUARTER_WORK = PI_WORK >>> 1;
    localparam longint                  TWO_PI_WORK  = 64'sd6746518856;
    localparam logic signed [ANG_W-1:0] PI_OUT_FULL  =
        (PI_WORK + (ANG_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    localparam logic signed [17:0]      PI_OUT       = 18'(PI_OUT_FULL);

    typedef struct packed {
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
    } coord_t;

    typedef struct packed {
        logic signed [15:0] spin_angle;
        logic        [14:0] polar_angle;
        logic signed [15:0] azimuth_angle;
        logic               last_of_run;
    } angle_t;

    // Angle pair handed from the math pipe to the row emitter
    typedef struct packed {
        logic        [14:0] polar;
        logic signed [15:0] azim;
    } run_t;

    // atan(2^-k) in Q30, rounded to nearest
    function automatic logic [31:0] atan_q30(input int k);
        logic [31:0] v;
        case (k)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Round a Q30 work angle to output precision (floor after adding half)
    function automatic logic signed [17:0] to_out(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] t;
        t = v + (ANG_W'(1) <<< (OUT_SHIFT - 1));
        return 18'(t >>> OUT_SHIFT);
    endfunction

endpackage

@@ sv/uves_sqrt_cell.sv @@
// One digit of the restoring integer square root.
// Depends on nothing beyond its ports.
module uves_sqrt_cell #(
    parameter int BIT_POS = 0,
    parameter int SIDE_W  = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [30:0]       rem_in,
    input  logic [30:0]       root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [30:0]       rem_out,
    output logic [30:0]       root_out,
    output logic [SIDE_W-1:0] side_out
);
    localparam logic [30:0] BIT = 31'(1) << (2 * BIT_POS);

    logic              valid_reg;
    logic [30:0]       rem_reg, rem_next;
    logic [30:0]       root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;
    logic [30:0]       trial;

    // Subtract the trial term when it fits
    always_comb begin
        trial = root_in + BIT;
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + BIT;
        end else begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;
endmodule

@@ sv/uves_cordic_cell.sv @@
// One vectoring micro-rotation of the arctangent CORDIC.
// Uses uves_pkg for the angle width and arctangent table.
module uves_cordic_cell #(
    parameter int K      = 0,
    parameter int SIDE_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [31:0]                vx_in,
    input  logic signed [31:0]                vy_in,
    input  logic signed [uves_pkg::ANG_W-1:0] ang_in,
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic signed [31:0]                vx_out,
    output logic signed [31:0]                vy_out,
    output logic signed [uves_pkg::ANG_W-1:0] ang_out,
    output logic [SIDE_W-1:0]                 side_out
);
    localparam logic signed [uves_pkg::ANG_W-1:0] ATAN =
        uves_pkg::ANG_W'(uves_pkg::atan_q30(K));

    logic                              valid_reg;
    logic signed [31:0]                vx_reg, vx_next, vy_reg, vy_next;
    logic signed [uves_pkg::ANG_W-1:0] ang_reg, ang_next;
    logic [SIDE_W-1:0]                 side_reg;
    logic signed [31:0]                dx, dy;

    // Rotate toward the x axis
    always_comb begin
        dx = vx_in >>> K;
        dy = vy_in >>> K;
        if (vy_in > 0) begin
            vx_next  = vx_in + dy;
            vy_next  = vy_in - dx;
            ang_next = ang_in + ATAN;
        end else begin
            vx_next  = vx_in - dy;
            vy_next  = vy_in + dx;
            ang_next = ang_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            ang_reg  <= ang_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign vx_out    = vx_reg;
    assign vy_out    = vy_reg;
    assign ang_out   = ang_reg;
    assign side_out  = side_reg;
endmodule

@@ sv/uves_acos.sv @@
// Pipelined arccosine of a Q2.14 value: square root chain, then CORDIC chain.
// Uses uves_pkg, uves_sqrt_cell and uves_cordic_cell.
module uves_acos #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [15:0]                in_c,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic signed [uves_pkg::ANG_W-1:0] out_angle,
    output logic [14:0]                       out_sine,
    output logic [SIDE_W-1:0]                 out_side
);
    localparam int SQ_N    = 15;
    localparam int SQ_SIDE = SIDE_W + 16;
    localparam int CO_SIDE = SIDE_W + 18;
    localparam int AW      = uves_pkg::ANG_W;

    // Front stage: magnitude and 1 - c^2
    logic               s0_valid_reg;
    logic [14:0]        s0_mag_reg;
    logic               s0_neg_reg;
    logic [30:0]        s0_v_reg;
    logic [SIDE_W-1:0]  s0_side_reg;
    logic signed [31:0] csq;
    logic signed [15:0] cabs;

    always_comb begin
        csq  = in_c * in_c;
        cabs = in_c[15] ? -in_c : in_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= in_valid;
        end
        if (en) begin
            s0_mag_reg  <= cabs[14:0];
            s0_neg_reg  <= in_c[15];
            s0_v_reg    <= 31'(32'sd268435456 - csq);
            s0_side_reg <= in_side;
        end
    end

    // Square root chain, one result bit per cell
    logic               sq_valid [0:SQ_N];
    logic [30:0]        sq_rem   [0:SQ_N];
    logic [30:0]        sq_root  [0:SQ_N];
    logic [SQ_SIDE-1:0] sq_side  [0:SQ_N];

    assign sq_valid[0] = s0_valid_reg;
    assign sq_rem[0]   = s0_v_reg;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {s0_side_reg, s0_mag_reg, s0_neg_reg};

    for (genvar i = 0; i < SQ_N; i++) begin : g_sq
        uves_sqrt_cell #(.BIT_POS(SQ_N - 1 - i), .SIDE_W(SQ_SIDE)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sq_valid[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_in  (sq_side[i]),
            .out_valid(sq_valid[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .side_out (sq_side[i+1])
        );
    end

    // Load the CORDIC vector from (|c|, sine)
    logic              cs_valid_reg;
    logic [14:0]       cs_mag_reg, cs_r_reg;
    logic              cs_neg_reg;
    logic [SIDE_W-1:0] cs_side_reg;
    logic [14:0]       sq_r;

    assign sq_r = sq_root[SQ_N][14:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_valid_reg <= 1'b0;
        end else if (en) begin
            cs_valid_reg <= sq_valid[SQ_N];
        end
        if (en) begin
            cs_r_reg    <= sq_r;
            cs_neg_reg  <= sq_side[SQ_N][0];
            cs_mag_reg  <= sq_side[SQ_N][15:1];
            cs_side_reg <= sq_side[SQ_N][SQ_SIDE-1:16];
        end
    end

    logic                 co_valid [0:STAGES];
    logic signed [31:0]   co_vx    [0:STAGES];
    logic signed [31:0]   co_vy    [0:STAGES];
    logic signed [AW-1:0] co_ang   [0:STAGES];
    logic [CO_SIDE-1:0]   co_side  [0:STAGES];

    assign co_valid[0] = cs_valid_reg;
    assign co_vx[0]    = $signed({3'b000, cs_mag_reg, 14'b0});
    assign co_vy[0]    = $signed({3'b000, cs_r_reg, 14'b0});
    assign co_ang[0]   = '0;
    assign co_side[0]  = {cs_side_reg, cs_neg_reg, cs_r_reg == 15'd0,
                          cs_mag_reg == 15'd0, cs_r_reg};

    for (genvar k = 0; k < STAGES; k++) begin : g_co
        uves_cordic_cell #(.K(k), .SIDE_W(CO_SIDE)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (co_valid[k]),
            .vx_in    (co_vx[k]),
            .vy_in    (co_vy[k]),
            .ang_in   (co_ang[k]),
            .side_in  (co_side[k]),
            .out_valid(co_valid[k+1]),
            .vx_out   (co_vx[k+1]),
            .vy_out   (co_vy[k+1]),
            .ang_out  (co_ang[k+1]),
            .side_out (co_side[k+1])
        );
    end

    // Clamp, apply the special cases and fold negative inputs
    logic                 fin_valid_reg;
    logic signed [AW-1:0] fin_angle_reg, fin_angle_next;
    logic [14:0]          fin_sine_reg;
    logic [SIDE_W-1:0]    fin_side_reg;
    logic signed [AW-1:0] a;
    logic [CO_SIDE-1:0]   co_last;

    assign co_last = co_side[STAGES];

    always_comb begin
        a = co_ang[STAGES];
        if (a < 0) begin
            a = '0;
        end
        if (a > uves_pkg::QUARTER_WORK) begin
            a = uves_pkg::QUARTER_WORK;
        end
        if (co_last[16]) begin
            a = '0;
        end else if (co_last[15]) begin
            a = uves_pkg::QUARTER_WORK;
        end
        fin_angle_next = co_last[17] ? uves_pkg::PI_WORK - a : a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= co_valid[STAGES];
        end
        if (en) begin
            fin_angle_reg <= fin_angle_next;
            fin_sine_reg  <= co_last[14:0];
            fin_side_reg  <= co_last[CO_SIDE-1:18];
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_angle = fin_angle_reg;
    assign out_sine  = fin_sine_reg;
    assign out_side  = fin_side_reg;
endmodule

@@ sv/uves_div_cell.sv @@
// One quotient bit of the restoring divider for the azimuth ratio.
// Depends on nothing beyond its ports.
module uves_div_cell #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [15:0]       rem_in,
    input  logic [13:0]       quo_in,
    input  logic [14:0]       div_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [15:0]       rem_out,
    output logic [13:0]       quo_out,
    output logic [14:0]       div_out,
    output logic [SIDE_W-1:0] side_out
);
    logic              valid_reg;
    logic [15:0]       rem_reg, rem_next;
    logic [13:0]       quo_reg, quo_next;
    logic [14:0]       div_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [15:0]       shifted;

    // Shift in one bit and subtract the divisor when it fits
    always_comb begin
        shifted = {rem_in[14:0], 1'b0};
        if (shifted >= {1'b0, div_in}) begin
            rem_next = shifted - {1'b0, div_in};
            quo_next = {quo_in[12:0], 1'b1};
        end else begin
            rem_next = shifted;
            quo_next = {quo_in[12:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= div_in;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign div_out   = div_reg;
    assign side_out  = side_reg;
endmodule

@@ sv/uves_emitter.sv @@
// Row emitter: repeats one angle pair over the spin angles of a run.
// Uses uves_pkg for types and the pi constants.
module uves_emitter #(
    parameter int MAX_DIVISIONS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [6:0]          divisions,
    input  logic                in_valid,
    input  uves_pkg::run_t      in_run,
    output logic                in_take,
    output logic                m_valid,
    input  logic                m_ready,
    output uves_pkg::angle_t    m_data
);
    localparam int AW    = uves_pkg::ANG_W;
    localparam int IDX_W = (MAX_DIVISIONS > 1) ? $clog2(MAX_DIVISIONS) : 1;

    // Quotient and remainder of 2pi over each row count
    logic [AW-1:0] tab_q [0:MAX_DIVISIONS-1];
    logic [6:0]    tab_r [0:MAX_DIVISIONS-1];

    for (genvar g = 0; g < MAX_DIVISIONS; g++) begin : g_tab
        localparam longint NV = g + 1;
        localparam longint QV = uves_pkg::TWO_PI_WORK / NV;
        localparam longint RV = uves_pkg::TWO_PI_WORK % NV;
        assign tab_q[g] = AW'(QV);
        assign tab_r[g] = 7'(RV);
    end

    logic                 valid_reg;
    logic                 last_reg, last_next;
    logic [6:0]           row_reg, row_next;
    logic [6:0]           rem_reg, rem_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [14:0]          polar_reg;
    logic signed [15:0]   azim_reg;
    logic signed [15:0]   spin_reg, spin_next;
    logic [6:0]           n_eff;
    logic [IDX_W-1:0]     idx;
    logic [7:0]           rem_sum;
    logic                 carry;
    logic                 step;
    logic signed [17:0]   spin_full;

    // Clamp the row count into the supported range
    always_comb begin
        if (divisions == 7'd0) begin
            n_eff = 7'd1;
        end else if (divisions > 7'(MAX_DIVISIONS)) begin
            n_eff = 7'(MAX_DIVISIONS);
        end else begin
            n_eff = divisions;
        end
        idx = IDX_W'(n_eff - 7'd1);
    end

    assign in_take = in_valid && (!valid_reg || (m_ready && last_reg));
    assign step    = valid_reg && m_ready && !last_reg;

    // Advance the rounded spin step by 2pi/n with carry from the remainder
    always_comb begin
        rem_sum = {1'b0, rem_reg} + {1'b0, tab_r[idx]};
        carry   = rem_sum >= {1'b0, n_eff};
        if (in_take) begin
            acc_next  = '0;
            rem_next  = n_eff >> 1;
            row_next  = 7'd0;
            last_next = n_eff == 7'd1;
        end else begin
            acc_next  = acc_reg + $signed(tab_q[idx]) + AW'(carry);
            rem_next  = carry ? 7'(rem_sum - {1'b0, n_eff}) : rem_sum[6:0];
            row_next  = row_reg + 7'd1;
            last_next = (row_reg + 7'd2) == n_eff;
        end
        spin_full = uves_pkg::to_out(acc_next - uves_pkg::PI_WORK);
        spin_next = spin_full[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= step;
        end
        if (in_take || step) begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            row_reg  <= row_next;
            last_reg <= last_next;
            spin_reg <= spin_next;
        end
        if (in_take) begin
            polar_reg <= in_run.polar;
            azim_reg  <= in_run.azim;
        end
    end

    assign m_valid              = valid_reg;
    assign m_data.spin_angle    = spin_reg;
    assign m_data.polar_angle   = polar_reg;
    assign m_data.azimuth_angle = azim_reg;
    assign m_data.last_of_run   = last_reg;

`ifndef NO_ASSERTIONS
    a_polar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> {3'b000, polar_reg} <= uves_pkg::PI_OUT)
        else $error("polar angle above pi");
    a_azim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ($signed(azim_reg) <= uves_pkg::PI_OUT &&
                       $signed(azim_reg) > -uves_pkg::PI_OUT))
        else $error("azimuth outside (-pi, pi]");
    a_run_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> valid_reg && $stable(polar_reg) && $stable(azim_reg))
        else $error("angle pair changed inside a run");
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> row_reg < n_eff)
        else $error("row index past row count");
`endif
endmodule

@@ sv/unit_vector_to_euler_sampler_top.sv @@
// Rows of a run leave the emitter one per cycle while m_ready is high.
// Throughput: a new vector enters every cycle through the cell chains unless
// en stalls them while the emitter holds a run; the emitter, giving one row
// per cycle, sets the sustained rate of divisions rows per vector, with
// divisions held to 1..MAX_DIVISIONS.
// Reset: synchronous active-low aresetn clears all valid bits; divisions = 1.
module unit_vector_to_euler_sampler_top #(
    parameter int MAX_DIVISIONS = 64,
    parameter int CORDIC_STAGES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  uves_pkg::coord_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output uves_pkg::angle_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [6:0]       cfg_data
);
    localparam int AW     = uves_pkg::ANG_W;
    localparam int DIV_N  = 14;
    localparam int DV_SIDE = 19;

    logic       en;
    logic [6:0] divisions_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisions_reg <= 7'd1;
        end else if (cfg_valid && cfg_ready) begin
            divisions_reg <= cfg_data;
        end
    end

    assign s_ready = en;

    // Polar angle from clamped z
    logic signed [15:0] zc;
    always_comb begin
        if (s_data.coord_z > 16'sd16384) begin
            zc = 16'sd16384;
        end else if (s_data.coord_z < -16'sd16384) begin
            zc = -16'sd16384;
        end else begin
            zc = s_data.coord_z;
        end
    end

    logic                 p_valid;
    logic signed [AW-1:0] p_angle;
    logic [14:0]          p_sine;
    logic [31:0]          p_side;

    uves_acos #(.STAGES(CORDIC_STAGES), .SIDE_W(32)) u_polar (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid && s_ready),
        .in_c     (zc),
        .in_side  ({s_data.coord_x, s_data.coord_y}),
        .out_valid(p_valid),
        .out_angle(p_angle),
        .out_sine (p_sine),
        .out_side (p_side)
    );

    // Round polar, set up the ratio |x| / sine
    logic               b_valid_reg;
    logic [14:0]        b_polar_reg;
    logic [14:0]        b_sine_reg;
    logic [15:0]        b_mag_reg;
    logic               b_szero_reg, b_sat_reg, b_rneg_reg, b_yneg_reg;
    logic signed [15:0] px, py;
    logic signed [16:0] mx;
    logic signed [17:0] p_out;

    always_comb begin
        px    = p_side[31:16];
        py    = p_side[15:0];
        mx    = px[15] ? -{px[15], px} : {px[15], px};
        p_out = uves_pkg::to_out(p_angle);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= p_valid;
        end
        if (en) begin
            b_polar_reg <= p_out[14:0];
            b_sine_reg  <= p_sine;
            b_mag_reg   <= mx[15:0];
            b_szero_reg <= p_sine == 15'd0;
            b_sat_reg   <= mx >= $signed({2'b00, p_sine});
            b_rneg_reg  <= px > 16'sd0;
            b_yneg_reg  <= py[15];
        end
    end

    // Divider chain, one quotient bit per cell
    logic               dv_valid [0:DIV_N];
    logic [15:0]        dv_rem   [0:DIV_N];
    logic [13:0]        dv_quo   [0:DIV_N];
    logic [14:0]        dv_div   [0:DIV_N];
    logic [DV_SIDE-1:0] dv_side  [0:DIV_N];

    assign dv_valid[0] = b_valid_reg;
    assign dv_rem[0]   = b_mag_reg;
    assign dv_quo[0]   = '0;
    assign dv_div[0]   = b_sine_reg;
    assign dv_side[0]  = {b_polar_reg, b_szero_reg, b_sat_reg, b_rneg_reg, b_yneg_reg};

    for (genvar i = 0; i < DIV_N; i++) begin : g_div
        uves_div_cell #(.SIDE_W(DV_SIDE)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dv_valid[i]),
            .rem_in   (dv_rem[i]),
            .quo_in   (dv_quo[i]),
            .div_in   (dv_div[i]),
            .side_in  (dv_side[i]),
            .out_valid(dv_valid[i+1]),
            .rem_out  (dv_rem[i+1]),
            .quo_out  (dv_quo[i+1]),
            .div_out  (dv_div[i+1]),
            .side_out (dv_side[i+1])
        );
    end

    // Signed, saturated ratio into the azimuth arccosine
    logic [DV_SIDE-1:0] dv_last;
    logic signed [15:0] qmag, ratio;
    assign dv_last = dv_side[DIV_N];
    always_comb begin
        qmag  = dv_last[2] ? 16'sd16384 : $signed({2'b00, dv_quo[DIV_N]});
        ratio = dv_last[1] ? -qmag : qmag;
    end

    logic                 a_valid;
    logic signed [AW-1:0] a_angle;
    logic [14:0]          a_sine;
    logic [16:0]          a_side;

    uves_acos #(.STAGES(CORDIC_STAGES), .SIDE_W(17)) u_azim (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dv_valid[DIV_N]),
        .in_c     (ratio),
        .in_side  ({dv_last[18:3], dv_last[0]}),
        .out_valid(a_valid),
        .out_angle(a_angle),
        .out_sine (a_sine),
        .out_side (a_side)
    );

    // Mirror for negative y, zero when sine vanished, wrap into (-pi, pi]
    logic               t_valid_reg;
    uves_pkg::run_t     t_run_reg;
    logic signed [17:0] az;
    logic               take;

    always_comb begin
        az = uves_pkg::to_out(a_angle);
        if (a_side[0]) begin
            az = (uves_pkg::PI_OUT <<< 1) - az;
        end
        if (a_side[1]) begin
            az = '0;
        end
        if (az > uves_pkg::PI_OUT) begin
            az = az - (uves_pkg::PI_OUT <<< 1);
        end
    end

    assign en = !t_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else if (en) begin
            t_valid_reg <= a_valid;
        end
        if (en) begin
            t_run_reg.polar <= a_side[16:2];
            t_run_reg.azim  <= az[15:0];
        end
    end

    // Sine of the azimuth angle is not needed downstream
    logic unused_sine;
    assign unused_sine = ^a_sine;

    uves_emitter #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .divisions(divisions_reg),
        .in_valid (t_valid_reg),
        .in_run   (t_run_reg),
        .in_take  (take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );
endmodule

@@ verif/uves_checker.sv @@
// Checker for the unit vector to Euler angle sampler: watches the input, result
// and divisions write channels, predicts each row and compares. Depends on uves_pkg.
module uves_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  uves_pkg::coord_t s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  uves_pkg::angle_t m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [6:0]       cfg_data,
    output int               errors,
    output int               rows_due,
    output int               rows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES   = 16;
    localparam int MAX_ROWS = 64;

    longint           arctan_q30 [STAGES];
    longint           pi_q30;
    logic [6:0]       divisions_reg;
    uves_pkg::angle_t rows_q [$];

    // atan(1/den) in Q60 by the alternating series
    function automatic longint arctan_inv_q60(longint unsigned den);
        longint unsigned den_sq, term, k;
        longint          acc;
        den_sq = den * den;
        term   = (64'd1 << 60) / den;
        k      = 0;
        acc    = 0;
        while (term != 0) begin
            acc  = (k & 1) ? acc - longint'(term / (2 * k + 1))
                           : acc + longint'(term / (2 * k + 1));
            term = term / den_sq;
            k++;
        end
        return acc;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // CORDIC vectoring angle of (xa, yb) in Q30, held within [0, pi/2]
    function automatic longint cordic_angle(longint xa, longint yb);
        longint vx, vy, dx, dy, ang, quarter;
        quarter = pi_q30 / 2;
        if (yb == 0) return 0;
        if (xa == 0) return quarter;
        vx  = xa * 16384;
        vy  = yb * 16384;
        ang = 0;
        for (int k = 0; k < STAGES; k++) begin
            dx = vx >>> k;
            dy = vy >>> k;
            if (vy > 0) begin
                vx += dy; vy -= dx; ang += arctan_q30[k];
            end else begin
                vx -= dy; vy += dx; ang -= arctan_q30[k];
            end
        end
        if (ang < 0) ang = 0;
        if (ang > quarter) ang = quarter;
        return ang;
    endfunction

    function automatic longint arccos_q30(longint c, output longint sine);
        longint mag, a;
        mag  = (c < 0) ? -c : c;
        sine = int_sqrt(longint'(268435456) - c * c);
        a    = cordic_angle(mag, sine);
        return (c < 0) ? pi_q30 - a : a;
    endfunction

    function automatic longint round_out(longint v);
        return (v + (longint'(1) << (uves_pkg::OUT_SHIFT - 1))) >>> uves_pkg::OUT_SHIFT;
    endfunction

    // Queue the rows one vector produces under the current divisions
    function automatic void predict_rows(uves_pkg::coord_t c);
        longint cx, cy, cz, sine, dummy, pi_o, polar, azim, mag, ratio, cnt, step;
        uves_pkg::angle_t row;
        cx   = c.coord_x;
        cy   = c.coord_y;
        cz   = c.coord_z;
        cnt  = divisions_reg;
        if (cnt < 1) cnt = 1;
        if (cnt > MAX_ROWS) cnt = MAX_ROWS;
        if (cz > uves_pkg::UNIT_Q14) cz = uves_pkg::UNIT_Q14;
        if (cz < -uves_pkg::UNIT_Q14) cz = -uves_pkg::UNIT_Q14;
        polar = round_out(arccos_q30(cz, sine));
        pi_o  = round_out(pi_q30);
        azim  = 0;
        if (sine != 0) begin
            mag   = (cx < 0) ? -cx : cx;
            ratio = (mag >= sine) ? uves_pkg::UNIT_Q14 : (mag * uves_pkg::UNIT_Q14) / sine;
            if (cx > 0) ratio = -ratio;
            azim = round_out(arccos_q30(ratio, dummy));
            if (cy < 0) azim = 2 * pi_o - azim;
        end
        if (azim > pi_o) azim -= 2 * pi_o;
        for (longint r = 0; r < cnt; r++) begin
            step              = (r * 2 * pi_q30 + cnt / 2) / cnt;
            row.spin_angle    = 16'(round_out(step - pi_q30));
            row.polar_angle   = 15'(polar);
            row.azimuth_angle = 16'(azim);
            row.last_of_run   = (r + 1 == cnt);
            rows_q.push_back(row);
        end
    endfunction

    initial begin
        errors    = 0;
        rows_due  = 0;
        rows_seen = 0;
        divisions_reg = 7'd1;
        arctan_q30[0] = (arctan_inv_q60(2) + arctan_inv_q60(3) + (longint'(1) << 29)) >>> 30;
        for (int k = 1; k < STAGES; k++)
            arctan_q30[k] = (arctan_inv_q60(64'd1 << k) + (longint'(1) << 29)) >>> 30;
        pi_q30 = 4 * arctan_q30[0];
    end

    // Track divisions, predict accepted vectors, compare delivered rows
    always @(posedge aclk) begin
        uves_pkg::angle_t want;
        if (!aresetn) begin
            divisions_reg = 7'd1;
            rows_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) divisions_reg = cfg_data;
            if (s_valid && s_ready) predict_rows(s_data);
            if (m_valid && m_ready) begin
                rows_seen++;
                if (rows_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected row, actual %p", $time, m_data);
                end else begin
                    want = rows_q.pop_front();
                    if (m_data.spin_angle !== want.spin_angle ||
                        m_data.polar_angle !== want.polar_angle ||
                        m_data.azimuth_angle !== want.azimuth_angle ||
                        m_data.last_of_run !== want.last_of_run) begin
                        errors++;
                        $display("%0t: row mismatch, expected %p, actual %p",
                                 $time, want, m_data);
                    end
                end
            end
        end
        rows_due = rows_q.size();
    end
endmodule

@@ verif/tb.sv @@
// Top of the sampler testbench: clock, reset, stimulus, divisions writes and
// verdict. Depends on uves_pkg, unit_vector_to_euler_sampler_top and uves_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN       = 120;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    uves_pkg::coord_t s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    uves_pkg::angle_t m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [6:0]       cfg_data = '0;

    int errors, rows_due, rows_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int vectors_sent = 0;
    int cycle_count = 0;

    unit_vector_to_euler_sampler_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    uves_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .rows_due(rows_due), .rows_seen(rows_seen)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one vector; starts and ends at a falling edge
    task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{coord_x: x, coord_y: y, coord_z: z};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        vectors_sent++;
        @(negedge aclk);
    endtask

    // Drain outstanding rows, then write divisions while idle
    task automatic set_divisions(input logic [6:0] value);
        s_valid <= 1'b0;
        while (rows_due != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_vector();
        int unsigned pick;
        logic [15:0] x, y, z;
        pick = $urandom_range(3);
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
        // Keep z inside the unit range for most vectors so the azimuth path works
        if (pick != 0) z = 16'($urandom_range(32768) - 16384);
        if (pick == 2) x = 16'($urandom_range(4096) - 2048);
        send_vector(x, y, z);
    endtask

    initial begin
        logic [6:0] div_plan [8];
        div_plan = '{7'd1, 7'd2, 7'd5, 7'd0, 7'd8, 7'd64, 7'd127, 7'd3};

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: poles, equator, clamps, mirror corners, extremes
        set_divisions(7'd3);
        send_vector(16'sd0, 16'sd0, 16'sd16384);
        send_vector(16'sd0, 16'sd0, -16'sd16384);
        send_vector(16'sd0, 16'sd0, 16'sd32767);
        send_vector(16'sd0, 16'sd0, -16'sd32768);
        send_vector(16'sd16384, 16'sd0, 16'sd0);
        send_vector(-16'sd16384, 16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sd16384, 16'sd0);
        send_vector(16'sd0, -16'sd16384, 16'sd0);
        send_vector(16'sd16384, -16'sd1, 16'sd0);
        send_vector(-16'sd16384, -16'sd1, 16'sd0);
        send_vector(16'sd11585, 16'sd11585, 16'sd0);
        send_vector(-16'sd11585, -16'sd11585, 16'sd0);
        send_vector(16'sd32767, 16'sd32767, 16'sd32767);
        send_vector(-16'sd32768, -16'sd32768, -16'sd32768);
        send_vector(16'sd0, 16'sd0, 16'sd0);
        send_vector(16'sd1, -16'sd1, 16'sd16383);
        send_vector(-16'sd1, 16'sd1, -16'sd16383);
        send_vector(16'sd9459, -16'sd9459, 16'sd9459);

        // Random: three idle profiles, divisions swept including extremes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 15 : 0;
            for (int d = 0; d < 8; d++) begin
                set_divisions(div_plan[d]);
                repeat ((div_plan[d] >= 64) ? 3 : 9) send_random_vector();
            end
        end

        s_valid <= 1'b0;
        while (rows_due != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);

        $display("Covered %0d vectors and %0d rows over divisions 0..127",
                 vectors_sent, rows_seen);
        $display("with three sender/receiver stall profiles.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
